[design/ptwc_pkg.sv]
// ----------------------------------------------------------------------------
// ptwc_pkg: shared types and constants
// Item formats, status and register codes, merge sequencer states and the
// calibrated homography coefficient table.
// ----------------------------------------------------------------------------
`default_nettype none

package ptwc_pkg;

    localparam int ROW_W     = 8;
    localparam int COL_W     = 9;
    localparam int CURV_W    = 24;
    localparam int STAT_W    = 2;
    localparam int COEF_W    = 32;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CIDX_W    = 6;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_COINC = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NEAR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR  = 1'd1;

    localparam logic [CFG_W-1:0] NEAR_RST = 8'd70;
    localparam logic [CFG_W-1:0] FAR_RST  = 8'd110;

    typedef struct packed {
        logic [ROW_W-1:0] row_a;
        logic [COL_W-1:0] col_a;
        logic [ROW_W-1:0] row_b;
        logic [COL_W-1:0] col_b;
        logic [ROW_W-1:0] row_c;
        logic [COL_W-1:0] col_c;
    } in_item_t;

    typedef struct packed {
        logic [CURV_W-1:0] curvature;
        logic [STAT_W-1:0] status;
    } out_item_t;

    typedef enum logic [3:0] {
        M_IDLE,
        M_DIFF,
        M_SQR,
        M_CHK,
        M_SQRT,
        M_MUL,
        M_D1GO,
        M_DIV1,
        M_D2GO,
        M_DIV2,
        M_DONE
    } merge_state_t;

    // Word zone*8+i is coefficient i of a zone; zones past the calibrated
    // three read as zero.
    function automatic logic signed [COEF_W-1:0] cal_coef(input logic [CIDX_W-1:0] idx);
        logic signed [COEF_W-1:0] c;
        case (idx)
            6'd0:    c = 32'sd964278;
            6'd1:    c = 32'sd9713472;
            6'd2:    c = -32'sd117179937;
            6'd3:    c = -32'sd939785;
            6'd4:    c = 32'sd382279;
            6'd5:    c = 32'sd223721029;
            6'd6:    c = 32'sd405502;
            6'd7:    c = 32'sd9289;
            6'd8:    c = 32'sd802471;
            6'd9:    c = 32'sd12659619;
            6'd10:   c = -32'sd152330776;
            6'd11:   c = 32'sd9103375;
            6'd12:   c = -32'sd396860;
            6'd13:   c = 32'sd260221315;
            6'd14:   c = 32'sd639954;
            6'd15:   c = 32'sd727;
            6'd16:   c = -32'sd252988;
            6'd17:   c = 32'sd12159962;
            6'd18:   c = -32'sd140329373;
            6'd19:   c = 32'sd8050702;
            6'd20:   c = -32'sd654894;
            6'd21:   c = 32'sd258032470;
            6'd22:   c = 32'sd616993;
            6'd23:   c = -32'sd3655;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[design/ptwc_div.sv]
// ----------------------------------------------------------------------------
// ptwc_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; quotient holds after done.
// ----------------------------------------------------------------------------
`default_nettype none

module ptwc_div #(
    parameter int NW = 44,
    parameter int DW = 44
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [NW-1:0] quotient,
    output logic          done
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic          fits;

    assign trial    = {rem_reg, quo_reg[NW-1]};
    assign fits     = trial >= {1'b0, den_reg};
    assign quotient = quo_reg;
    assign done     = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(NW);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - CW'(1);
            done_reg <= (cnt_reg == CW'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

endmodule

`default_nettype wire

[design/ptwc_sqrt.sv]
// ----------------------------------------------------------------------------
// ptwc_sqrt: iterative integer square root
// Floor square root, one result bit per cycle from the top bit pair down.
// ----------------------------------------------------------------------------
`default_nettype none

module ptwc_sqrt #(
    parameter int RW = 21
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [2*RW-1:0] radicand,
    output logic [RW-1:0]   root,
    output logic            done
);
    localparam int CW = $clog2(RW + 1);

    logic [2*RW-1:0] rad_reg;
    logic [RW+1:0]   rem_reg;
    logic [RW-1:0]   root_reg;
    logic [CW-1:0]   cnt_reg;
    logic            done_reg;
    logic [RW+3:0]   shifted;
    logic [RW+1:0]   trial;
    logic            fits;

    assign shifted = {rem_reg, rad_reg[2*RW-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign fits    = shifted >= (RW+4)'(trial);
    assign root    = root_reg;
    assign done    = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(RW);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - CW'(1);
            done_reg <= (cnt_reg == CW'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= fits ? (RW+2)'(shifted - (RW+4)'(trial)) : (RW+2)'(shifted);
            root_reg <= {root_reg[RW-2:0], fits};
            rad_reg  <= {rad_reg[2*RW-3:0], 2'b00};
        end
    end

endmodule

`default_nettype wire

[design/ptwc_lane.sv]
// ----------------------------------------------------------------------------
// ptwc_lane: pixel to ground mapping of one point
// Picks the zone homography, forms numerators and denominator, then divides
// both axes in parallel and clamps to the signed ground range, or gives zero for a bad denominator.
// ----------------------------------------------------------------------------
`default_nettype none

module ptwc_lane #(
    parameter int WORLD_BITS = 12,
    parameter int ZONE_COUNT = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [ptwc_pkg::ROW_W-1:0]          row,
    input  logic [ptwc_pkg::COL_W-1:0]          col,
    input  logic [ptwc_pkg::CFG_W-1:0]          near_limit,
    input  logic [ptwc_pkg::CFG_W-1:0]          far_limit,
    output logic signed [WORLD_BITS-1:0]        x,
    output logic signed [WORLD_BITS-1:0]        y,
    output logic                                done
);
    import ptwc_pkg::*;

    localparam int AW = 44;
    localparam int PW = 42;
    localparam int ZW = 3;
    localparam logic [AW-1:0] LIM_A = AW'((1 << (WORLD_BITS - 1)) - 1);
    localparam logic signed [AW-1:0] Q24_ONE = {{(AW-25){1'b0}}, 1'b1, 24'b0};

    logic [ZW-1:0]               zone_raw;
    logic [ZW-1:0]               zone;
    logic [CIDX_W-1:0]           base;
    logic signed [COEF_W-1:0]    c_reg [8];
    logic [ROW_W-1:0]            row_reg;
    logic [COL_W-1:0]            col_reg;
    logic signed [PW-1:0]        p_reg [6];
    logic signed [AW-1:0]        numx_reg;
    logic signed [AW-1:0]        numy_reg;
    logic signed [AW-1:0]        den_reg;
    logic [2:0]                  ph_reg;
    logic [AW-1:0]               magx;
    logic [AW-1:0]               magy;
    logic [AW-1:0]               qx;
    logic [AW-1:0]               qy;
    logic                        dx_done;
    logic                        dy_done;
    logic                        den_bad;
    logic signed [WORLD_BITS-1:0] x_reg;
    logic signed [WORLD_BITS-1:0] y_reg;
    logic                        done_reg;
    logic signed [PW-1:0]        row_s;
    logic signed [PW-1:0]        col_s;

    function automatic logic signed [WORLD_BITS-1:0] clamp(input logic [AW-1:0] q,
                                                            input logic neg,
                                                            input logic bad);
        logic signed [WORLD_BITS-1:0] v;
        if (bad)
            v = '0;
        else if (!neg)
            v = (q > LIM_A) ? WORLD_BITS'(LIM_A) : q[WORLD_BITS-1:0];
        else
            v = (q > LIM_A + AW'(1)) ? -WORLD_BITS'(LIM_A + AW'(1))
                                     : -q[WORLD_BITS-1:0];
        return v;
    endfunction

    always_comb
    begin
        priority if (row < near_limit)
            zone_raw = ZW'(0);
        else if (row > far_limit)
            zone_raw = ZW'(2);
        else
            zone_raw = ZW'(1);
        zone = (int'(zone_raw) >= ZONE_COUNT) ? ZW'(ZONE_COUNT - 1) : zone_raw;
        base = {zone, 3'b000};
    end

    assign row_s   = PW'($signed({1'b0, row_reg}));
    assign col_s   = PW'($signed({1'b0, col_reg}));
    assign magx    = numx_reg[AW-1] ? AW'(-numx_reg) : AW'(numx_reg);
    assign magy    = numy_reg[AW-1] ? AW'(-numy_reg) : AW'(numy_reg);
    assign den_bad = den_reg[AW-1] || (den_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= {ph_reg[1:0], start};
            done_reg <= dx_done & dy_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            row_reg <= row;
            col_reg <= col;
            for (int i = 0; i < 8; i++)
                c_reg[i] <= cal_coef(base + CIDX_W'(i));
        end
        if (ph_reg[0])
        begin
            p_reg[0] <= PW'(c_reg[0]) * row_s;
            p_reg[1] <= PW'(c_reg[1]) * col_s;
            p_reg[2] <= PW'(c_reg[3]) * row_s;
            p_reg[3] <= PW'(c_reg[4]) * col_s;
            p_reg[4] <= PW'(c_reg[6]) * row_s;
            p_reg[5] <= PW'(c_reg[7]) * col_s;
        end
        if (ph_reg[1])
        begin
            numx_reg <= AW'(p_reg[0]) + AW'(p_reg[1]) + (AW'(c_reg[2]) <<< 4);
            numy_reg <= AW'(p_reg[2]) + AW'(p_reg[3]) + (AW'(c_reg[5]) <<< 4);
            den_reg  <= AW'(p_reg[4]) + AW'(p_reg[5]) + Q24_ONE;
        end
        if (dx_done)
        begin
            x_reg <= clamp(qx, numx_reg[AW-1], den_bad);
            y_reg <= clamp(qy, numy_reg[AW-1], den_bad);
        end
    end

    // numerator truncated to an integer, then scaled back by 2^24
    ptwc_div #(.NW(AW), .DW(AW)) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ph_reg[2]),
        .dividend ({magx[AW-1:24], 24'b0}),
        .divisor  (AW'(den_reg)),
        .quotient (qx),
        .done     (dx_done)
    );

    ptwc_div #(.NW(AW), .DW(AW)) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ph_reg[2]),
        .dividend ({magy[AW-1:24], 24'b0}),
        .divisor  (AW'(den_reg)),
        .quotient (qy),
        .done     (dy_done)
    );

    assign x    = x_reg;
    assign y    = y_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

[design/ptwc_merge.sv]
// ----------------------------------------------------------------------------
// ptwc_merge: curvature from three ground points
// Side lengths, triangle area and the two fractional divisions of the Menger
// curvature, run by a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ptwc_merge #(
    parameter int WORLD_BITS     = 12,
    parameter int CURV_FRAC_BITS = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [WORLD_BITS-1:0]      xa,
    input  logic signed [WORLD_BITS-1:0]      ya,
    input  logic signed [WORLD_BITS-1:0]      xb,
    input  logic signed [WORLD_BITS-1:0]      yb,
    input  logic signed [WORLD_BITS-1:0]      xc,
    input  logic signed [WORLD_BITS-1:0]      yc,
    input  logic                              ack,
    output logic                              idle,
    output logic                              valid,
    output ptwc_pkg::out_item_t               result
);
    import ptwc_pkg::*;

    localparam int W   = WORLD_BITS;
    localparam int DXW = W + 1;
    localparam int SQW = 2 * DXW;
    localparam int D2W = 2 * W + 2;
    localparam int RW  = W + 9;
    localparam int CRW = SQW + 1;
    localparam int S4W = CRW + 1;
    localparam int PW  = 2 * RW;
    localparam int N1W = S4W + 32;
    localparam int K   = CURV_FRAC_BITS - 8;
    localparam int N2W = 32 + K;

    merge_state_t state_reg;
    merge_state_t state_next;

    logic signed [W-1:0]   pxa_reg, pya_reg, pxb_reg, pyb_reg, pxc_reg, pyc_reg;
    logic signed [DXW-1:0] dxab_reg, dyab_reg, dxac_reg, dyac_reg, dxbc_reg, dybc_reg;
    logic signed [SQW-1:0] sq_abx, sq_aby, sq_acx, sq_acy, sq_bcx, sq_bcy;
    logic signed [SQW-1:0] pr1, pr2;
    logic [D2W-1:0]        d2ab_reg, d2ac_reg, d2bc_reg;
    logic signed [CRW-1:0] cross_reg;
    logic [CRW-1:0]        cross_abs;
    logic [S4W-1:0]        s4_reg;
    logic [PW-1:0]         prod_reg;
    logic [RW-1:0]         lab, lac, lbc;
    logic                  sq_done_ab, sq_done_ac, sq_done_bc;
    logic                  sq_done;
    logic [N1W-1:0]        q1;
    logic [N2W-1:0]        q2;
    logic                  d1_done, d2_done;
    logic                  sat1, sat1_reg, sat2;
    logic [31:0]           ratio;
    logic                  coinc;
    logic                  sqrt_start, div1_start, div2_start;
    logic [CURV_W-1:0]     curv_reg;
    logic [STAT_W-1:0]     stat_reg;

    assign sq_abx = dxab_reg * dxab_reg;
    assign sq_aby = dyab_reg * dyab_reg;
    assign sq_acx = dxac_reg * dxac_reg;
    assign sq_acy = dyac_reg * dyac_reg;
    assign sq_bcx = dxbc_reg * dxbc_reg;
    assign sq_bcy = dybc_reg * dybc_reg;
    assign pr1    = dxab_reg * dyac_reg;
    assign pr2    = dxac_reg * dyab_reg;

    assign cross_abs = cross_reg[CRW-1] ? CRW'(-cross_reg) : CRW'(cross_reg);
    assign coinc     = (d2ab_reg == '0) || (d2ac_reg == '0) || (d2bc_reg == '0);
    assign sq_done   = sq_done_ab & sq_done_ac & sq_done_bc;
    assign sat1      = |q1[N1W-1:32];
    assign ratio     = sat1 ? 32'hFFFF_FFFF : q1[31:0];
    assign sat2      = |q2[N2W-1:CURV_W];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            M_IDLE: if (start) state_next = M_DIFF;
            M_DIFF: state_next = M_SQR;
            M_SQR:  state_next = M_CHK;
            M_CHK:  state_next = coinc ? M_DONE : M_SQRT;
            M_SQRT: if (sq_done) state_next = M_MUL;
            M_MUL:  state_next = M_D1GO;
            M_D1GO: state_next = M_DIV1;
            M_DIV1: if (d1_done) state_next = M_D2GO;
            M_D2GO: state_next = M_DIV2;
            M_DIV2: if (d2_done) state_next = M_DONE;
            M_DONE: if (ack) state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    always_comb
    begin
        idle       = (state_reg == M_IDLE);
        valid      = (state_reg == M_DONE);
        sqrt_start = (state_reg == M_CHK) && !coinc;
        div1_start = (state_reg == M_D1GO);
        div2_start = (state_reg == M_D2GO);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= M_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (idle && start)
        begin
            pxa_reg <= xa;
            pya_reg <= ya;
            pxb_reg <= xb;
            pyb_reg <= yb;
            pxc_reg <= xc;
            pyc_reg <= yc;
        end
        if (state_reg == M_DIFF)
        begin
            dxab_reg <= DXW'(pxb_reg) - DXW'(pxa_reg);
            dyab_reg <= DXW'(pyb_reg) - DXW'(pya_reg);
            dxac_reg <= DXW'(pxc_reg) - DXW'(pxa_reg);
            dyac_reg <= DXW'(pyc_reg) - DXW'(pya_reg);
            dxbc_reg <= DXW'(pxc_reg) - DXW'(pxb_reg);
            dybc_reg <= DXW'(pyc_reg) - DXW'(pyb_reg);
        end
        if (state_reg == M_SQR)
        begin
            d2ab_reg  <= D2W'($unsigned(sq_abx)) + D2W'($unsigned(sq_aby));
            d2ac_reg  <= D2W'($unsigned(sq_acx)) + D2W'($unsigned(sq_acy));
            d2bc_reg  <= D2W'($unsigned(sq_bcx)) + D2W'($unsigned(sq_bcy));
            cross_reg <= CRW'(pr1) - CRW'(pr2);
        end
        if ((state_reg == M_CHK) && coinc)
        begin
            curv_reg <= '0;
            stat_reg <= ST_COINC;
        end
        if (state_reg == M_MUL)
        begin
            prod_reg <= PW'(lab) * PW'(lac);
            // doubled area halved with truncation, then times four
            s4_reg   <= {cross_abs[CRW-1:1], 2'b00};
        end
        if (state_reg == M_D2GO)
            sat1_reg <= sat1;
        if ((state_reg == M_DIV2) && d2_done)
        begin
            if (sat1_reg || sat2)
            begin
                curv_reg <= '1;
                stat_reg <= ST_SAT;
            end
            else
            begin
                curv_reg <= q2[CURV_W-1:0];
                stat_reg <= ST_OK;
            end
        end
    end

    ptwc_sqrt #(.RW(RW)) u_sqrt_ab (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({d2ab_reg, 16'b0}),
        .root     (lab),
        .done     (sq_done_ab)
    );

    ptwc_sqrt #(.RW(RW)) u_sqrt_ac (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({d2ac_reg, 16'b0}),
        .root     (lac),
        .done     (sq_done_ac)
    );

    ptwc_sqrt #(.RW(RW)) u_sqrt_bc (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({d2bc_reg, 16'b0}),
        .root     (lbc),
        .done     (sq_done_bc)
    );

    ptwc_div #(.NW(N1W), .DW(PW)) u_div_ratio (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div1_start),
        .dividend ({s4_reg, 32'b0}),
        .divisor  (prod_reg),
        .quotient (q1),
        .done     (d1_done)
    );

    ptwc_div #(.NW(N2W), .DW(RW)) u_div_curv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div2_start),
        .dividend (N2W'(ratio) << K),
        .divisor  (lbc),
        .quotient (q2),
        .done     (d2_done)
    );

    assign result.curvature = curv_reg;
    assign result.status    = stat_reg;

endmodule

`default_nettype wire

[design/pixel_to_world_curvature.sv]
// ----------------------------------------------------------------------------
// pixel_to_world_curvature: three-point road curvature from camera pixels
// Input channel (in_valid/in_ready/in_data) takes three pixel points; three
// mapping lanes turn them into ground points side by side, and a merge
// stage computes the Menger curvature and status. Output channel
// (out_valid/out_ready/out_data) carries one result item per input item.
// The lanes run three setup stages and a 44-step divider, then hand their
// points over; the merge then runs its square-root units and two bit-serial
// dividers up to the output register, while coincident points skip the
// square roots and divisions. Lanes and merge overlap.
// The lanes take a new item as soon as the merge has picked up their points.
// A result waiting in the output register lets the merge start the next
// item; a stalled receiver holds the merge in its done state.
// Reset clears all control, sets the zone row limits to 70 and 110 and
// leaves both channels empty. The configuration port writes the limit
// chosen by cfg_index when cfg_we is high.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_to_world_curvature #(
    parameter int ZONE_COUNT     = 3,
    parameter int WORLD_BITS     = 12,
    parameter int CURV_FRAC_BITS = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  ptwc_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output ptwc_pkg::out_item_t             out_data,
    input  logic                            cfg_we,
    input  logic [ptwc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ptwc_pkg::CFG_W-1:0]      cfg_data
);
    import ptwc_pkg::*;

    logic [CFG_W-1:0]             near_reg;
    logic [CFG_W-1:0]             far_reg;
    logic                         busy_reg;
    logic                         pts_rdy_reg;
    logic                         out_valid_reg;
    out_item_t                    out_data_reg;
    logic                         accept;
    logic [ROW_W-1:0]             rows [3];
    logic [COL_W-1:0]             cols [3];
    logic signed [WORLD_BITS-1:0] px [3];
    logic signed [WORLD_BITS-1:0] py [3];
    logic [2:0]                   lane_done;
    logic                         merge_start;
    logic                         merge_idle;
    logic                         merge_valid;
    logic                         merge_ack;
    out_item_t                    merge_result;

    assign in_ready    = !busy_reg;
    assign accept      = in_valid && in_ready;
    assign merge_start = pts_rdy_reg && merge_idle;
    assign merge_ack   = !out_valid_reg || out_ready;

    assign rows[0] = in_data.row_a;
    assign rows[1] = in_data.row_b;
    assign rows[2] = in_data.row_c;
    assign cols[0] = in_data.col_a;
    assign cols[1] = in_data.col_b;
    assign cols[2] = in_data.col_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg <= NEAR_RST;
            far_reg  <= FAR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NEAR: near_reg <= cfg_data;
                CFG_FAR:  far_reg  <= cfg_data;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pts_rdy_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // lanes stay busy until the merge has latched their points
            if (accept)
                busy_reg <= 1'b1;
            else if (merge_start)
                busy_reg <= 1'b0;

            if (lane_done[0])
                pts_rdy_reg <= 1'b1;
            else if (merge_start)
                pts_rdy_reg <= 1'b0;

            if (merge_valid && merge_ack)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (merge_valid && merge_ack)
            out_data_reg <= merge_result;
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        ptwc_lane #(
            .WORLD_BITS (WORLD_BITS),
            .ZONE_COUNT (ZONE_COUNT)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .start      (accept),
            .row        (rows[g]),
            .col        (cols[g]),
            .near_limit (near_reg),
            .far_limit  (far_reg),
            .x          (px[g]),
            .y          (py[g]),
            .done       (lane_done[g])
        );
    end

    ptwc_merge #(
        .WORLD_BITS     (WORLD_BITS),
        .CURV_FRAC_BITS (CURV_FRAC_BITS)
    ) u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (merge_start),
        .xa     (px[0]),
        .ya     (py[0]),
        .xb     (px[1]),
        .yb     (py[1]),
        .xc     (px[2]),
        .yc     (py[2]),
        .ack    (merge_ack),
        .idle   (merge_idle),
        .valid  (merge_valid),
        .result (merge_result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        lane_done[0] == lane_done[1] && lane_done[1] == lane_done[2])
        else $error("mapping lanes finished out of step");

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        lane_done[0] |-> busy_reg)
        else $error("lane result without an item in flight");

    a_start_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        merge_start |-> !in_ready)
        else $error("merge started while lanes were free");

    a_coinc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_COINC |-> out_data.curvature == '0)
        else $error("coincident result with nonzero curvature");
`endif

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: pixel_to_world_curvature testbench
// Sends pixel point triples over the input channel under random idle gaps,
// predicts ground mapping and Menger curvature per item with a bit-exact
// fixed-point model, and checks each result in order. Covers zone limit
// settings, coincident, collinear and saturating triples, and backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import ptwc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_NEAR;
    logic [CFG_W-1:0]     cfg_data = '0;

    out_item_t   curv_expect_q[$];
    int          fail_count = 0;
    int          ready_hold = 0;
    logic [7:0]  near_limit = NEAR_RST;
    logic [7:0]  far_limit = FAR_RST;

    localparam int SETTLE_CYCLES = 300;
    localparam int IN_W = $bits(in_item_t);
    localparam longint ONE_Q24 = 64'sd16777216;

    // Calibrated homography, zone*8+i
    const longint homography[24] = '{
        964278, 9713472, -117179937, -939785, 382279, 223721029, 405502, 9289,
        802471, 12659619, -152330776, 9103375, -396860, 260221315, 639954, 727,
        -252988, 12159962, -140329373, 8050702, -654894, 258032470, 616993, -3655};

    pixel_to_world_curvature dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------- prediction ----------------
    function automatic longint ground_axis(int zone, longint row, longint col, int k);
        longint num;
        longint den;
        longint whole;
        longint q;
        num = homography[zone*8+k] * row + homography[zone*8+k+1] * col
              + homography[zone*8+k+2] * 16;
        den = homography[zone*8+6] * row + homography[zone*8+7] * col + ONE_Q24;
        if (den <= 0)
            return 0;
        whole = (num >= 0) ? (num >>> 24) : -((-num) >>> 24);
        q = (whole * ONE_Q24) / den;
        if (q > 2047)
            q = 2047;
        if (q < -2048)
            q = -2048;
        return q;
    endfunction

    function automatic void ground_point(logic [7:0] row, logic [8:0] col,
                                         output longint x, output longint y);
        int zone;
        if (row < near_limit)
            zone = 0;
        else if (row > far_limit)
            zone = 2;
        else
            zone = 1;
        x = ground_axis(zone, longint'(row), longint'(col), 0);
        y = ground_axis(zone, longint'(row), longint'(col), 3);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] frac_divide(logic [63:0] num, logic [63:0] den, int k,
                                                logic [63:0] cap, inout bit sat);
        logic [63:0] q;
        logic [63:0] rem;
        q = num / den;
        rem = num % den;
        if (q > cap)
        begin
            sat = 1'b1;
            return cap;
        end
        for (int i = 0; i < k; i++)
        begin
            rem <<= 1;
            q <<= 1;
            if (rem >= den)
            begin
                rem -= den;
                q |= 1;
            end
            if (q > cap)
            begin
                sat = 1'b1;
                return cap;
            end
        end
        return q;
    endfunction

    function automatic out_item_t predict_curvature(in_item_t d);
        longint xa, ya, xb, yb, xc, yc, area2;
        logic [63:0] dab, dac, dbc, lab, lac, lbc, s4, ratio, curv;
        bit sat;
        out_item_t res;
        sat = 1'b0;
        ground_point(d.row_a, d.col_a, xa, ya);
        ground_point(d.row_b, d.col_b, xb, yb);
        ground_point(d.row_c, d.col_c, xc, yc);
        dab = (xa-xb)*(xa-xb) + (ya-yb)*(ya-yb);
        dac = (xa-xc)*(xa-xc) + (ya-yc)*(ya-yc);
        dbc = (xb-xc)*(xb-xc) + (yb-yc)*(yb-yc);
        if (dab == 0 || dac == 0 || dbc == 0)
        begin
            res.curvature = '0;
            res.status = ST_COINC;
            return res;
        end
        area2 = (xb-xa)*(yc-ya) - (xc-xa)*(yb-ya);
        if (area2 < 0)
            area2 = -area2;
        s4 = ($unsigned(area2) / 2) * 4;
        lab = int_sqrt(dab << 16);
        lac = int_sqrt(dac << 16);
        lbc = int_sqrt(dbc << 16);
        ratio = frac_divide(s4, lab * lac, 32, 64'hFFFF_FFFF, sat);
        curv = frac_divide(ratio, lbc, 12, 64'hFF_FFFF, sat);
        if (sat)
        begin
            res.curvature = '1;
            res.status = ST_SAT;
        end
        else
        begin
            res.curvature = curv[23:0];
            res.status = ST_OK;
        end
        return res;
    endfunction

    // ---------------- result side ----------------
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            out_ready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else if ($urandom_range(0, 3) == 0)
            out_ready <= ($urandom_range(0, 9) == 0) ? 1'b1 : 1'b0;
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        out_item_t exp_item;
        if (rst_n && out_valid && out_ready)
        begin
            if (curv_expect_q.size() == 0)
            begin
                $error("result with no item pending: curvature %0d status %0d",
                       out_data.curvature, out_data.status);
                fail_count++;
            end
            else
            begin
                exp_item = curv_expect_q.pop_front();
                if (out_data.curvature !== exp_item.curvature)
                begin
                    $error("curvature: expected %0d, got %0d",
                           exp_item.curvature, out_data.curvature);
                    fail_count++;
                end
                if (out_data.status !== exp_item.status)
                begin
                    $error("status: expected %0d, got %0d",
                           exp_item.status, out_data.status);
                    fail_count++;
                end
            end
        end
    end

    // ---------------- stimulus helpers ----------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_triple(in_item_t d, int gap);
        in_valid <= 1'b1;
        in_data <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        curv_expect_q.push_back(predict_curvature(d));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic in_item_t triple(int ra, int ca, int rb, int cb, int rc, int cc);
        in_item_t d;
        d.row_a = ROW_W'(ra); d.col_a = COL_W'(ca);
        d.row_b = ROW_W'(rb); d.col_b = COL_W'(cb);
        d.row_c = ROW_W'(rc); d.col_c = COL_W'(cc);
        return d;
    endfunction

    function automatic in_item_t random_triple();
        in_item_t d;
        int mode;
        d = in_item_t'(IN_W'({$urandom, $urandom}));
        mode = $urandom_range(0, 9);
        // pull points together to reach coincident and saturated results
        if (mode < 2)
        begin
            d.row_b = ROW_W'(d.row_a + $urandom_range(0, 2));
            d.col_b = COL_W'(d.col_a + $urandom_range(0, 3));
            d.row_c = ROW_W'(d.row_a + $urandom_range(0, 2));
            d.col_c = COL_W'(d.col_a + $urandom_range(0, 3));
        end
        else if (mode == 2)
            d.row_c = d.row_b;
        return d;
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (curv_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limits(logic [7:0] near_v, logic [7:0] far_v);
        cfg_we <= 1'b1;
        cfg_index <= CFG_NEAR;
        cfg_data <= near_v;
        @(posedge clk);
        cfg_index <= CFG_FAR;
        cfg_data <= far_v;
        @(posedge clk);
        cfg_we <= 1'b0;
        near_limit = near_v;
        far_limit = far_v;
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        send_triple(triple(0, 0, 0, 0, 0, 0), pick_gap());          // coincident
        send_triple(triple(255, 511, 255, 511, 255, 511), pick_gap());
        send_triple(triple(0, 0, 255, 511, 128, 256), pick_gap());
        send_triple(triple(255, 0, 0, 511, 128, 0), pick_gap());
        send_triple(triple(0, 511, 255, 0, 69, 300), pick_gap());
        send_triple(triple(69, 100, 70, 200, 110, 300), pick_gap()); // zone edges
        send_triple(triple(111, 100, 110, 250, 70, 400), pick_gap());
        send_triple(triple(100, 10, 100, 250, 100, 500), pick_gap()); // collinear
        send_triple(triple(40, 256, 90, 256, 150, 256), pick_gap());
        send_triple(triple(50, 200, 50, 200, 90, 300), pick_gap());  // A equals B
        send_triple(triple(50, 200, 90, 300, 90, 300), pick_gap());  // B equals C
        send_triple(triple(60, 200, 61, 201, 60, 202), pick_gap());  // tight bend
        send_triple(triple(200, 300, 201, 300, 200, 301), pick_gap());
        send_triple(triple(30, 0, 30, 1, 31, 0), pick_gap());
        send_triple(triple(170, 85, 85, 170, 42, 341), pick_gap());
        send_triple(triple(255, 255, 0, 256, 127, 511), pick_gap());
        wait_drained();
    endtask

    task automatic test_zone_limits();
        write_limits(8'd0, 8'd0);
        repeat (40) send_triple(random_triple(), pick_gap());
        wait_drained();
        write_limits(8'd255, 8'd255);
        repeat (40) send_triple(random_triple(), pick_gap());
        wait_drained();
        write_limits(8'd255, 8'd0);
        repeat (40) send_triple(random_triple(), pick_gap());
        wait_drained();
        write_limits(8'd0, 8'd255);
        repeat (40) send_triple(random_triple(), pick_gap());
        wait_drained();
    endtask

    task automatic test_backpressure();
        ready_hold = 800;
        repeat (30) send_triple(random_triple(), 0);
        wait_drained();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 0)
                write_limits(NEAR_RST, FAR_RST);
            else
                write_limits(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            repeat (210) send_triple(random_triple(), pick_gap());
            wait_drained();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_zone_limits();
        test_backpressure();
        test_random();
        if (fail_count == 0 && curv_expect_q.size() == 0)
            $display("pixel_to_world_curvature test passed");
        else
            $display("pixel_to_world_curvature test failed");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("pixel_to_world_curvature test failed");
        $finish;
    end

endmodule

`default_nettype wire
